### src/jfs_pkg.sv
package jfs_pkg;

   // Configuration register indexes
   localparam logic [3:0] CSR_ROW_COUNT = 4'd0;
   localparam logic [3:0] CSR_COL_COUNT = 4'd1;

   localparam logic [15:0] ROW_COUNT_RESET = 16'd1024;
   localparam logic [10:0] COL_COUNT_RESET = 11'd1024;

   // 0.2 in Q0.16, rounded down
   localparam logic [13:0] AVG_SCALE = 14'd13107;

   localparam int SAMPLE_WIDTH = 16;
   localparam int SUM_WIDTH = 19;
   localparam int PROD_WIDTH = 33;

   typedef struct packed {
      logic [15:0] sample;
      logic        start_of_grid;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] value;
      logic [15:0] cell_row;
      logic [9:0]  cell_col;
      logic        last_of_grid;
   } rsp_payload_type;

endpackage

### src/jfs_ram.sv
module jfs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/jacobi_five_point_stencil_core.sv
// A result passes the read stage, the sum stage and the output register after the edge
//   that accepts the sample that completes its cell.
// Throughput: one sample per cycle unless rsp_ready stalls, set by one read per port.
// Reset (synchronous, active high): position to (0,0), window to zero, pipeline empty,
//   row_count and col_count to 1024. Line buffer contents are left as they are.
module jacobi_five_point_stencil_core
   import jfs_pkg::*;
#(
   parameter int LINE_WIDTH = 1024
) (
   input  logic            clock,
   input  logic            reset,
   // sample requests
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   // results
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   // register writes
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [3:0]      csr_index,
   input  logic [15:0]     csr_data
);

   // column index width and a width that also holds the column count
   localparam int CW = $clog2(LINE_WIDTH);
   localparam int EW = CW + 1;
   localparam logic [EW-1:0] LW_E = EW'(LINE_WIDTH);

   //------------------------------------------------------------------
   // Configuration registers
   //------------------------------------------------------------------
   logic [15:0] row_count_ff;
   logic [10:0] col_count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROW_COUNT_RESET;
         col_count_ff <= COL_COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ROW_COUNT: row_count_ff <= csr_data;
            CSR_COL_COUNT: col_count_ff <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   // Effective grid size: column count capped at the line length, zero counts as one.
   logic [EW-1:0] cols_eff;
   logic [EW-1:0] cols_m1;
   logic [EW-1:0] cols_m2;
   logic [15:0]   rows_eff;
   logic [15:0]   rows_m1;
   logic          grid_ok;

   always_comb begin
      if (32'(col_count_ff) > LINE_WIDTH) begin
         cols_eff = LW_E;
      end else if (col_count_ff == 11'd0) begin
         cols_eff = EW'(1);
      end else begin
         cols_eff = EW'(col_count_ff);
      end
      rows_eff = (row_count_ff == 16'd0) ? 16'd1 : row_count_ff;
      cols_m1  = cols_eff - EW'(1);
      cols_m2  = cols_eff - EW'(2);
      rows_m1  = rows_eff - 16'd1;
      grid_ok  = (rows_eff >= 16'd3) && (cols_eff >= EW'(3));
   end

   //------------------------------------------------------------------
   // Pipeline control: every stage moves when the output register is
   // free or is being drained. Items that produce no result travel as
   // bubbles, so they never hold up the stream.
   //------------------------------------------------------------------
   logic adv;
   logic req_take;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign req_take  = req_valid && adv;

   //------------------------------------------------------------------
   // Stage 0: position of the incoming sample, line buffer reads
   //------------------------------------------------------------------
   logic [15:0]   row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;

   logic [15:0]   pos_r_raw, pos_r;
   logic [CW-1:0] pos_j_raw, pos_j;
   logic [EW-1:0] j_e, j_next_e;
   logic          emit, last, wrap, right_ok;
   logic [CW-1:0] rd_right_addr;

   always_comb begin
      pos_r_raw = req_data.start_of_grid ? 16'd0 : row_ff;
      pos_j_raw = req_data.start_of_grid ? '0 : col_ff;
      // a position left over from a larger grid is pulled back to the edge
      pos_j = (EW'(pos_j_raw) >= cols_eff) ? CW'(cols_m1) : pos_j_raw;
      pos_r = (pos_r_raw >= rows_eff) ? rows_m1 : pos_r_raw;
      j_e      = EW'(pos_j);
      j_next_e = j_e + EW'(1);
      // cell (r-1, j) completes with this sample when it lies inside the border
      emit = grid_ok && (pos_r >= 16'd2) && (pos_j != '0) &&
             ((j_e + EW'(2)) <= cols_eff);
      last = (pos_r == rows_m1) && (j_e == cols_m2);
      wrap = (j_next_e >= cols_eff);
      col_in = wrap ? '0 : CW'(j_next_e);
      if (!wrap) begin
         row_in = pos_r;
      end else if (pos_r == rows_m1) begin
         row_in = 16'd0;
      end else begin
         row_in = pos_r + 16'd1;
      end
      // right neighbour lies past the line at its last column
      right_ok      = (j_next_e < LW_E);
      rd_right_addr = right_ok ? CW'(j_next_e) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= 16'd0;
         col_ff <= '0;
      end else if (req_take) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   //------------------------------------------------------------------
   // Stage 1: line buffer data, forwarding, five-term sum, write back
   //------------------------------------------------------------------
   logic                    s1_valid_ff;
   logic [15:0]             s1_sample_ff;
   logic [CW-1:0]           s1_j_ff;
   logic                    s1_emit_ff;
   logic                    s1_last_ff;
   logic                    s1_right_ok_ff;
   logic [15:0]             s1_row_ff;
   // same-edge write bypass: the RAM returns the old word on a collision
   logic                    s1_fwd_c_ff, s1_fwd_r_ff, s1_fwd_u_ff;
   logic [15:0]             s1_fwd_prev_ff, s1_fwd_up_ff;
   logic [15:0]             left_ff;

   logic [15:0] prev_c_q, prev_r_q, second_q;
   logic [15:0] centre, up, right;
   logic        s1_wr;
   logic [SUM_WIDTH-1:0] sum;

   assign s1_wr = adv && s1_valid_ff;

   always_comb begin
      centre = s1_fwd_c_ff ? s1_fwd_prev_ff : prev_c_q;
      up     = s1_fwd_u_ff ? s1_fwd_up_ff : second_q;
      if (!s1_right_ok_ff) begin
         right = 16'd0;
      end else if (s1_fwd_r_ff) begin
         right = s1_fwd_prev_ff;
      end else begin
         right = prev_r_q;
      end
      sum = SUM_WIDTH'(centre) + SUM_WIDTH'(up) + SUM_WIDTH'(right) +
            SUM_WIDTH'(left_ff) + SUM_WIDTH'(s1_sample_ff);
   end

   // previous row line, kept twice so centre and right are read in the same cycle
   jfs_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(LINE_WIDTH)) u_prev_c (
      .clock   (clock),
      .wr_en   (s1_wr),
      .wr_addr (s1_j_ff),
      .wr_data (s1_sample_ff),
      .rd_en   (adv),
      .rd_addr (pos_j),
      .rd_data (prev_c_q)
   );

   jfs_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(LINE_WIDTH)) u_prev_r (
      .clock   (clock),
      .wr_en   (s1_wr),
      .wr_addr (s1_j_ff),
      .wr_data (s1_sample_ff),
      .rd_en   (adv),
      .rd_addr (rd_right_addr),
      .rd_data (prev_r_q)
   );

   // row two above: takes the old previous-row word as it is displaced
   jfs_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(LINE_WIDTH)) u_second (
      .clock   (clock),
      .wr_en   (s1_wr),
      .wr_addr (s1_j_ff),
      .wr_data (centre),
      .rd_en   (adv),
      .rd_addr (pos_j),
      .rd_data (second_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         left_ff     <= 16'd0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         if (s1_valid_ff) begin
            left_ff <= centre;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sample_ff   <= req_data.sample;
         s1_j_ff        <= pos_j;
         s1_emit_ff     <= emit;
         s1_last_ff     <= last;
         s1_right_ok_ff <= right_ok;
         s1_row_ff      <= pos_r - 16'd1;
         s1_fwd_c_ff    <= s1_valid_ff && (s1_j_ff == pos_j);
         s1_fwd_u_ff    <= s1_valid_ff && (s1_j_ff == pos_j);
         s1_fwd_r_ff    <= s1_valid_ff && (s1_j_ff == rd_right_addr);
         s1_fwd_prev_ff <= s1_sample_ff;
         s1_fwd_up_ff   <= centre;
      end
   end

   //------------------------------------------------------------------
   // Stage 2: scale by 0.2 (multiply by 13107, keep bits 31:16)
   //------------------------------------------------------------------
   logic                 s2_valid_ff;
   logic [SUM_WIDTH-1:0] s2_sum_ff;
   logic [15:0]          s2_row_ff;
   logic [9:0]           s2_col_ff;
   logic                 s2_last_ff;
   logic [PROD_WIDTH-1:0] prod;

   // sum is at most 5 * 65535, so the product stays below 2^32
   assign prod = PROD_WIDTH'(s2_sum_ff) * PROD_WIDTH'(AVG_SCALE);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_sum_ff  <= sum;
         s2_row_ff  <= s1_row_ff;
         s2_col_ff  <= 10'(s1_j_ff);
         s2_last_ff <= s1_last_ff;
      end
   end

   //------------------------------------------------------------------
   // Output register
   //------------------------------------------------------------------
   rsp_payload_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.value        <= prod[31:16];
         rsp_data_ff.cell_row     <= s2_row_ff;
         rsp_data_ff.cell_col     <= s2_col_ff;
         rsp_data_ff.last_of_grid <= s2_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   //------------------------------------------------------------------
   // Checks
   //------------------------------------------------------------------
   // results only ever come from interior cells
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.cell_row != 16'd0) && (rsp_data_ff.cell_col != 10'd0))
      else $error("result on a boundary cell");

   // a start request puts the next position at column one, or zero on a one-column grid
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.start_of_grid) |=> (col_ff == CW'(1) || col_ff == '0))
      else $error("start request did not restart the column position");

   // the last cell of the grid sits in the second-to-last column
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.last_of_grid) |->
         (rsp_data_ff.cell_col == 10'(cols_m2)))
      else $error("last_of_grid on the wrong column");

   // a stalled read stage keeps its line buffer words and writes nothing
   assert property (@(posedge clock) disable iff (reset)
      (!adv && s1_valid_ff) |=> ($stable(centre) && $stable(up) && $stable(right)))
      else $error("read stage data changed during a stall");

endmodule
